@@ hdl/nns_pkg.sv @@
package nns_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int COUNT_W   = $clog2(MAX_NODES + 1);
  localparam int COORD_W   = 24;
  localparam int ID_W      = 16;
  localparam int DIST_W    = 2 * (COORD_W + 1) + 1;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic [15:0] GRID_SPACING_RESET = 16'd256;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [ID_W-1:0]     node_id;
    logic signed [23:0]  pos_x;
    logic signed [23:0]  pos_z;
    logic [15:0]         max_distance;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] nearest_id;
    logic            near_found;
    logic            on_mesh;
    logic [1:0]      status;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } node_t;

endpackage

@@ hdl/nearest_node_search_xz.sv @@
// nearest node search in the xz plane over a table of navigation nodes
//
// item channel (item_valid / item_stall, payload item): one transaction is
// an add, a nearest query or a clear. result channel (result_valid /
// result_stall, payload result): exactly one transaction per item, in order.
// cfg_we / cfg_data write grid_spacing; write it only while the block is idle.
//
// add, clear and the unused request code finish in the accepting cycle: the
// result is valid on the next cycle. a query streams the node memory, one
// entry per cycle through a three stage distance pipeline, and its result
// follows once the scan has drained the pipeline; the single read port of
// the node memory sets that rate. a query on an empty table answers at once.
// a new item is taken only when idle and when the result register is empty
// or its transaction completes in that same cycle.
//
// reset empties the table, restores grid_spacing to 1.0 and drops any
// pending result; node memory contents are not cleared. a stalled receiver
// holds the result register and, while it holds it, the item side as well.
module nearest_node_search_xz (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  nns_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output nns_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data
);
  import nns_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // node memory, one entry per node in load order
  node_t mem [MAX_NODES];

  logic [1:0]         state;
  logic [15:0]        grid_spacing;
  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] issue_cnt;

  // query operands held for the whole scan
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qz;
  logic [31:0]               max_sq;
  logic [33:0]               near_sq;

  // pipeline
  logic                       v1, v2, v3;
  node_t                      rd_data;
  logic [COORD_W:0]           mag_x, mag_z;
  logic [ID_W-1:0]            id2, id3;
  logic [2*(COORD_W+1)-1:0]   sq_x, sq_z;

  // running best
  logic              first;
  logic [DIST_W-1:0] best_dist;
  logic [ID_W-1:0]   best_id;
  logic              any_in;

  logic              item_acc;
  logic              out_free;
  logic              result_load;
  logic              rd_en;
  logic              is_add;
  logic              table_full;
  logic signed [COORD_W:0] dx, dz;
  logic [DIST_W-1:0] node_dist;
  logic              dist_better;
  logic [16:0]       twice_grid;
  result_t           result_next;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == ST_IDLE) && out_free);
  assign item_acc   = item_valid && !item_stall;
  assign is_add     = item.req_type == REQ_ADD;
  assign table_full = node_count == COUNT_W'(MAX_NODES);
  assign rd_en      = (state == ST_SCAN) && (issue_cnt != node_count);
  assign twice_grid = {grid_spacing, 1'b0};

  // a result enters the output register: at once for anything but a scan,
  // or when a scan has finished
  assign result_load = (item_acc && !(item.req_type == REQ_QUERY && node_count != '0)) ||
                       (state == ST_DONE && out_free);

  // stage one: signed differences to magnitudes
  assign dx = {qx[COORD_W-1], qx} - {rd_data.x[COORD_W-1], rd_data.x};
  assign dz = {qz[COORD_W-1], qz} - {rd_data.z[COORD_W-1], rd_data.z};

  // stage three: squared distance and first-wins compare
  assign node_dist   = DIST_W'(sq_x) + DIST_W'(sq_z);
  assign dist_better = first || (node_dist < best_dist);

  // result for items that finish at acceptance
  always_comb begin
    result_next = '0;
    case (item.req_type)
      REQ_ADD:   if (table_full) result_next.status = STATUS_FULL;
      REQ_QUERY: result_next.status = STATUS_EMPTY;
      default:   result_next = '0;
    endcase
  end

  // node memory: append on add, streamed read during a query
  always_ff @(posedge clk) begin
    if (item_acc && is_add && !table_full) begin
      mem[node_count[ADDR_W-1:0]] <= '{id: item.node_id, x: item.pos_x, z: item.pos_z};
    end
    if (rd_en) begin
      rd_data <= mem[issue_cnt[ADDR_W-1:0]];
    end
  end

  // distance pipeline payload
  always_ff @(posedge clk) begin
    mag_x <= dx[COORD_W] ? (~dx + 1'b1) : dx;
    mag_z <= dz[COORD_W] ? (~dz + 1'b1) : dz;
    id2   <= rd_data.id;
    sq_x  <= mag_x * mag_x;
    sq_z  <= mag_z * mag_z;
    id3   <= id2;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      grid_spacing <= GRID_SPACING_RESET;
      node_count   <= '0;
      issue_cnt    <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        grid_spacing <= cfg_data;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2;
      if (rd_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            if (item.req_type == REQ_QUERY && node_count != '0) begin
              state     <= ST_SCAN;
              issue_cnt <= '0;
            end else begin
              if (is_add && !table_full) begin
                node_count <= node_count + 1'b1;
              end
              if (item.req_type == REQ_CLEAR) begin
                node_count <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          // all reads issued and the pipeline drained
          if (!rd_en && !v1 && !v2 && !v3) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // query operands, running best and result register payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_acc) begin
      qx      <= item.pos_x;
      qz      <= item.pos_z;
      max_sq  <= {16'b0, item.max_distance} * {16'b0, item.max_distance};
      near_sq <= {17'b0, twice_grid} * {17'b0, twice_grid};
      first   <= 1'b1;
      any_in  <= 1'b0;
      result  <= result_next;
    end
    if (v3) begin
      first <= 1'b0;
      if (dist_better) begin
        best_dist <= node_dist;
        best_id   <= id3;
      end
      if (node_dist <= DIST_W'(max_sq)) begin
        any_in <= 1'b1;
      end
    end
    if (state == ST_DONE && out_free) begin
      result.nearest_id <= best_id;
      result.near_found <= best_dist <= DIST_W'(near_sq);
      result.on_mesh    <= any_in;
      result.status     <= STATUS_OK;
    end
  end

endmodule

@@ hdl/nns_checker.sv @@
module nns_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input nns_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input nns_pkg::result_t result
);
  import nns_pkg::*;

  // a waiting result is not withdrawn
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // a waiting result does not change
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result changed while stalled");

  // anything but a query answers on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.req_type != REQ_QUERY |=> result_valid)
    else $error("non-query transaction not answered next cycle");

  // a failed transaction carries no search flags and no id
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |->
      result.nearest_id == '0 && !result.near_found && !result.on_mesh)
    else $error("search fields set on a failed transaction");

endmodule

bind nearest_node_search_xz nns_checker u_nns_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ verif/nearest_node_search_xz_test.sv @@
`timescale 1ns / 1ps

module nearest_node_search_xz_test;
  import nns_pkg::*;

  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  localparam int RESET_CYCLES = 8;
  // every item gives exactly one result, so a short tail catches stray ones
  localparam int TAIL_CYCLES  = 32;
  // the slowest correct run, full-table queries included, stays far below this
  localparam int CYCLE_LIMIT  = 400000;
  // countable transactions per random phase, four phases in all
  localparam int PHASE_ITEMS  = 140;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    cfg_we       = 1'b0;
  logic [15:0] cfg_data = '0;
  logic    item_stall;
  logic    result_valid;
  result_t result;

  // transactions waiting for the driver, answers waiting for the monitor
  item_t   item_backlog[$];
  result_t pending_answers[$];

  // own copy of the node table and the grid spacing register
  node_t       model_nodes [MAX_NODES];
  int          model_count   = 0;
  logic [15:0] model_spacing = GRID_SPACING_RESET;

  // nodes placed by the generator, so queries can aim at real positions
  node_t placed[$];
  int    issued_items = 0;

  // idling controls and counters; the two percentages change only between phases
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned calm_left      = 0;
  int unsigned cycle_count    = 0;
  int          fault_count    = 0;

  nearest_node_search_xz dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // squared gap along one axis, exact in 64 bits
  function automatic longint unsigned axis_gap_sq(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    longint gap;
    gap = longint'(a) - longint'(b);
    if (gap < 0) begin
      gap = -gap;
    end
    return $unsigned(gap) * $unsigned(gap);
  endfunction

  // applies one transaction to the table copy and returns the answer the
  // block owes for it
  function automatic result_t nearest_answer(item_t req);
    result_t         ans;
    longint unsigned gap_sq;
    longint unsigned best;
    longint unsigned reach;
    longint unsigned near_sq;
    int              best_at;
    ans = '0;
    case (req.req_type)
      REQ_ADD: begin
        if (model_count >= MAX_NODES) begin
          ans.status = STATUS_FULL;
        end else begin
          model_nodes[model_count] = '{id: req.node_id, x: req.pos_x, z: req.pos_z};
          model_count++;
        end
      end
      REQ_QUERY: begin
        if (model_count == 0) begin
          ans.status = STATUS_EMPTY;
        end else begin
          reach   = req.max_distance;
          reach   = reach * reach;
          near_sq = model_spacing;
          near_sq = 2 * near_sq;
          near_sq = near_sq * near_sq;
          best    = '1;
          best_at = 0;
          // strict less-than keeps the earliest node on a tie
          for (int n = 0; n < model_count; n++) begin
            gap_sq = axis_gap_sq(req.pos_x, model_nodes[n].x)
                   + axis_gap_sq(req.pos_z, model_nodes[n].z);
            if (n == 0 || gap_sq < best) begin
              best    = gap_sq;
              best_at = n;
            end
            if (gap_sq <= reach) begin
              ans.on_mesh = 1'b1;
            end
          end
          ans.nearest_id = model_nodes[best_at].id;
          ans.near_found = (best <= near_sq);
        end
      end
      REQ_CLEAR: begin
        model_count = 0;
      end
      default: begin
        // unused code: no state change, all-zero answer
      end
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds the backlog, predicts each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        pending_answers.push_back(nearest_answer(item));
      end
      // payload only moves once the current transaction has gone
      if (!item_valid || !item_stall) begin
        if (item_backlog.size() != 0 &&
            !(calm_left == 0 && $urandom_range(99) < send_idle_pct)) begin
          item       <= item_backlog.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result with the oldest outstanding answer
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    result_t due;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_answers.size() == 0) begin
          $error("result transaction with no answer outstanding: %p", result);
          fault_count++;
        end else begin
          due = pending_answers.pop_front();
          check_field("nearest_id", due.nearest_id, result.nearest_id);
          check_field("near_found", due.near_found, result.near_found);
          check_field("on_mesh", due.on_mesh, result.on_mesh);
          check_field("status", due.status, result.status);
        end
      end
      result_stall <= (calm_left == 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // cycle limit, plus short calm stretches where neither side idles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(63) == 0) begin
      calm_left <= $urandom_range(40, 10);
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic [1:0] kind, logic [15:0] id,
                            logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] z,
                            logic [15:0] reach);
    item_t next;
    next.req_type     = kind;
    next.node_id      = id;
    next.pos_x        = x;
    next.pos_z        = z;
    next.max_distance = reach;
    item_backlog.push_back(next);
    if (kind == REQ_ADD && placed.size() < MAX_NODES) begin
      placed.push_back('{id: id, x: x, z: z});
    end else if (kind == REQ_CLEAR) begin
      placed.delete();
    end
    if (kind != REQ_UNUSED) begin
      issued_items++;
    end
  endtask

  // clear or unused code with every other field random
  task automatic queue_bare(logic [1:0] kind);
    queue_item(kind, 16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
  endtask

  // coordinate within spread of a cluster centre, wrapping at 24 bits
  function automatic logic signed [COORD_W-1:0] scatter(logic signed [COORD_W-1:0] centre,
                                                       int unsigned spread);
    return centre + 24'($urandom_range(2 * spread)) - 24'(spread);
  endfunction

  // half of the radii small so that on_mesh goes both ways
  function automatic logic [15:0] pick_reach();
    return ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(4095));
  endfunction

  task automatic queue_add(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cz,
                           int unsigned spread);
    if ($urandom_range(9) == 0) begin
      queue_item(REQ_ADD, 16'($urandom), 24'($urandom), 24'($urandom), pick_reach());
    end else begin
      queue_item(REQ_ADD, 16'($urandom), scatter(cx, spread), scatter(cz, spread),
                 pick_reach());
    end
  endtask

  // queries aim at a stored node, at a node plus a radius (on_mesh edge),
  // anywhere in the plane, or around the cluster
  task automatic queue_query(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cz,
                             int unsigned spread);
    node_t                     pick;
    int unsigned               step;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qz;
    logic [15:0]               reach;
    reach = pick_reach();
    qx    = scatter(cx, spread);
    qz    = scatter(cz, spread);
    if (placed.size() != 0) begin
      pick = placed[$urandom_range(placed.size() - 1)];
      case ($urandom_range(3))
        0: begin
          qx = pick.x;
          qz = pick.z;
        end
        1: begin
          step  = $urandom_range(65535);
          qx    = pick.x + 24'(step);
          qz    = pick.z;
          reach = 16'(step);
          if (step != 0 && $urandom_range(1) == 1) begin
            reach = reach - 16'd1;
          end
        end
        2: begin
          qx = 24'($urandom);
          qz = 24'($urandom);
        end
        default: begin
        end
      endcase
    end
    queue_item(REQ_QUERY, 16'($urandom), qx, qz, reach);
  endtask

  // mostly clear, fill a cluster, then query it; now and then the table is
  // left to grow, a query lands on an empty table or an unused code slips in
  task automatic random_session();
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
    int unsigned               spread;
    int unsigned               adds;
    int unsigned               asks;
    cx     = 24'($urandom);
    cz     = 24'($urandom);
    spread = 1 << $urandom_range(14, 2);
    if (placed.size() > 200 || $urandom_range(7) != 0) begin
      queue_bare(REQ_CLEAR);
    end
    adds = ($urandom_range(9) == 0) ? 0 : $urandom_range(30, 1);
    asks = $urandom_range(8, 1);
    repeat (adds) queue_add(cx, cz, spread);
    repeat (asks) begin
      if ($urandom_range(9) == 0) begin
        queue_bare(REQ_UNUSED);
      end
      if ($urandom_range(7) == 0) begin
        queue_add(cx, cz, spread);
      end
      queue_query(cx, cz, spread);
    end
  endtask

  // wait until the block holds nothing; sampled at the falling edge so the
  // driver and monitor have settled
  task automatic drain();
    do begin
      @(negedge clk);
    end while (item_backlog.size() != 0 || item_valid || pending_answers.size() != 0);
  endtask

  task automatic write_spacing(logic [15:0] value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_data      <= value;
    model_spacing  = value;
    @(posedge clk);
    cfg_we        <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned               spacing_plan [4];
    int                        send_plan [4];
    int                        stall_plan [4];
    int                        mark;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;

    spacing_plan = '{1, 65535, 0, 0};
    send_plan    = '{0, 86, 0, 23};
    stall_plan   = '{0, 0, 86, 23};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset spacing of 1.0
    queue_item(REQ_QUERY, 16'h0000, 24'sd0, 24'sd0, 16'hFFFF);       // empty table
    queue_item(REQ_ADD, 16'hFFFF, COORD_MAX, COORD_MIN, 16'hFFFF);
    queue_item(REQ_ADD, 16'h0000, COORD_MIN, COORD_MAX, 16'h0000);
    queue_item(REQ_ADD, 16'h1234, 24'sd0, 24'sd0, 16'h0000);
    queue_item(REQ_ADD, 16'h5678, 24'sd0, 24'sd0, 16'h0000);        // same spot, loses
    queue_item(REQ_QUERY, 16'hFFFF, 24'sd0, 24'sd0, 16'h0000);      // exact hit, zero radius
    queue_item(REQ_QUERY, 16'h0000, COORD_MAX, COORD_MAX, 16'hFFFF); // far from all
    queue_item(REQ_QUERY, 16'h0000, COORD_MIN, COORD_MIN, 16'hFFFF);
    queue_item(REQ_UNUSED, 16'hFFFF, COORD_MIN, COORD_MIN, 16'hFFFF);
    queue_item(REQ_QUERY, 16'h0000, COORD_MAX, COORD_MIN, 16'h0000); // table unchanged
    queue_item(REQ_CLEAR, 16'hFFFF, -24'sd1, -24'sd1, 16'hFFFF);
    // equal distances from the origin: the first one loaded wins; 512 is
    // exactly twice the spacing, so near_found sits on its boundary
    queue_item(REQ_ADD, 16'h00A1, 24'sd512, 24'sd0, 16'h0000);
    queue_item(REQ_ADD, 16'h00A2, -24'sd512, 24'sd0, 16'h0000);
    queue_item(REQ_QUERY, 16'h0000, 24'sd0, 24'sd0, 16'd511);       // radius just short
    queue_item(REQ_QUERY, 16'h0000, 24'sd0, 24'sd0, 16'd512);       // radius just enough
    queue_item(REQ_QUERY, 16'h0000, 24'sd0, 24'sd1, 16'd512);       // just outside
    queue_item(REQ_CLEAR, 16'h0000, 24'sd0, 24'sd0, 16'h0000);
    queue_item(REQ_QUERY, 16'h0000, 24'sd0, 24'sd0, 16'hFFFF);      // empty after clear
    queue_item(REQ_UNUSED, 16'h0000, 24'sd0, 24'sd0, 16'h0000);
    queue_item(REQ_ADD, 16'h8001, -24'sd1, 24'sd1, 16'hFFFF);
    queue_item(REQ_QUERY, 16'h7FFE, -24'sd1, 24'sd1, 16'h0000);
    drain();

    // random phases: spacing at its lowest nonzero value, highest, zero (exact match only)
    // and random, each under its own idling pattern
    spacing_plan[3] = $urandom_range(65535, 1);
    for (int p = 0; p < 4; p++) begin
      write_spacing(16'(spacing_plan[p]));
      send_idle_pct  = send_plan[p];
      recv_stall_pct = stall_plan[p];
      mark = issued_items;
      while (issued_items - mark < PHASE_ITEMS) begin
        random_session();
      end
      drain();
    end

    // fill the table to the brim, overflow it, query it full, then empty it, query it empty and with one node
    write_spacing(16'd512);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cx = 24'($urandom);
    cz = 24'($urandom);
    queue_bare(REQ_CLEAR);
    repeat (MAX_NODES + 3) queue_add(cx, cz, 1 << 14);
    repeat (3) queue_query(cx, cz, 1 << 14);
    queue_add(cx, cz, 1 << 14);
    queue_bare(REQ_CLEAR);
    queue_query(cx, cz, 1 << 14);
    queue_add(cx, cz, 1 << 14);
    queue_query(cx, cz, 1 << 14);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
